>>> sv/correlation_pattern_counter_assert.svh
// assertion macros for the correlation pattern counter
`ifndef CORRELATION_PATTERN_COUNTER_ASSERT_SVH
`define CORRELATION_PATTERN_COUNTER_ASSERT_SVH

// same-cycle implication
`define CPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/cpc_pkg.sv
package cpc_pkg;

   localparam int FUNC_W  = 2;
   localparam int IDX_W   = 6;
   localparam int FREQ_W  = 16;
   localparam int SCALE_W = 16;
   localparam int COUNT_W = 18;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [FUNC_W-1:0] FUNC_LOAD_ELEMENT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_FREQ    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_START        = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED       = 2'd3;

   localparam logic [1:0] REG_SCALED_MODE  = 2'd0;
   localparam logic [1:0] REG_EVERY_TRIPLE = 2'd1;
   localparam logic [1:0] REG_ROW_COUNT    = 2'd2;
   localparam logic [1:0] REG_COLUMN_COUNT = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROOT,
      ST_SCALE_WR,
      ST_PAIR_RD,
      ST_PAIR_MUL,
      ST_PAIR_CMP,
      ST_KLOOP,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

>>> sv/cpc_req_if.sv
interface cpc_req_if
   import cpc_pkg::*;
#(
   parameter int VALUE_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic [FUNC_W-1:0]             func;
   logic [IDX_W-1:0]              row_index;
   logic [IDX_W-1:0]              column_index;
   logic signed [VALUE_WIDTH-1:0] element_value;
   logic [FREQ_W-1:0]             frequency;

   modport source (output valid, func, row_index, column_index, element_value, frequency,
                   input ready);
   modport sink (input valid, func, row_index, column_index, element_value, frequency,
                 output ready);
endinterface

>>> sv/cpc_rsp_if.sv
interface cpc_rsp_if
   import cpc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] flag_count;

   modport source (output valid, flag_count, input ready);
   modport sink (input valid, flag_count, output ready);
endinterface

>>> sv/correlation_pattern_counter.sv
// correlation pattern counter
// req_chan takes beats of three kinds: func 0 writes one matrix element, func 1 loads
// a row frequency, func 2 starts a count over the stored matrix. only func 2 gives a
// beat on rsp_chan, carrying the saturating flag count. csr registers (scaled mode,
// count every triple, row count, column count) are to be written over apb only while
// idle; the block itself does not enforce it. an element load writes the matrix
// memory when its beat is taken. for a frequency load the scale is found by a 16-step
// root unit, one bit a cycle, then written to the scale memory. for a count, per row
// pair the matrix memory is read at two ports, one column a cycle, through a four-stage
// read / multiply / magnitude / compare pipeline that drains before the next pair.
// the next beat is taken once the current one has finished; the finished count sits
// in an output register, so loads go on while rsp_chan stalls, and a new count
// waits at its end until the previous result is taken.
// reset clears the control state and csr registers; the memories are not cleared
// and an entry must be written before a count reads it.
`include "correlation_pattern_counter_assert.svh"

module correlation_pattern_counter
   import cpc_pkg::*;
#(
   parameter int MAX_SIZE    = 64,
   parameter int VALUE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   cpc_req_if.sink     req_chan,
   cpc_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW        = $clog2(MAX_SIZE);
   localparam int CW        = $clog2(MAX_SIZE + 1);
   localparam int CW1       = CW + 1;
   localparam int MDEPTH    = 1 << (2 * AW);
   localparam int SDEPTH    = 1 << AW;
   localparam int PW        = VALUE_WIDTH + SCALE_W + 1;
   localparam int SW        = PW + 1;
   localparam int ONE_SHIFT = VALUE_WIDTH - 2;
   localparam logic [8:0] SIZE_LIM = 9'(MAX_SIZE);

   function automatic logic [SW-1:0] mag_of(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] neg;
      neg = -v;
      return v[SW-1] ? unsigned'(neg) : unsigned'(v);
   endfunction

   state_type state_ff, state_in;

   logic                   scaled_ff, triple_ff;
   logic [6:0]             row_count_ff, column_count_ff;
   logic [CW-1:0]          n_eff, m_eff;
   logic [CW-1:0]          i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [3:0]             bit_ff, bit_in;
   logic [SCALE_W-1:0]     r_ff, r_in;
   logic [AW-1:0]          row_ff, row_in;
   logic [SCALE_W-1:0]     si_ff, si_in, sj_ff, sj_in;
   logic [SW-1:0]          r12_ff, r12_in, r21_ff, r21_in;
   logic                   hit_ff, hit_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                   v1_ff, v2_ff, v3_ff;
   logic                   issue_v;
   logic [31:0]            v_ff;
   logic signed [PW-1:0]   pa_ff, pb_ff, mul_a, mul_b;
   logic [SW-1:0]          lhs_ff;

   logic                   acc, mat_we, scale_we, flag;
   logic [AW-1:0]          in_row, in_col, col_a;
   logic                   row_ok, col_ok;
   logic [SCALE_W-1:0]     t_root, si_use, sj_use, mul_as, mul_bs;
   logic [31:0]            t_sq, v_calc;
   logic signed [VALUE_WIDTH-1:0] mul_bx;
   logic signed [SW-1:0]   unit_i, unit_j, lhs_sum;
   logic [CW1-1:0]         j_next, i_next2;

   logic signed [VALUE_WIDTH-1:0] mat_mem [MDEPTH];
   logic [SCALE_W-1:0]            scale_mem [SDEPTH];
   logic signed [VALUE_WIDTH-1:0] mat_rd_a_ff, mat_rd_b_ff;
   logic [SCALE_W-1:0]            scale_rd_a_ff, scale_rd_b_ff;

   // csr port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scaled_ff       <= 1'b0;
         triple_ff       <= 1'b0;
         row_count_ff    <= '0;
         column_count_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_SCALED_MODE:  scaled_ff       <= pwdata[0];
            REG_EVERY_TRIPLE: triple_ff       <= pwdata[0];
            REG_ROW_COUNT:    row_count_ff    <= pwdata[6:0];
            REG_COLUMN_COUNT: column_count_ff <= pwdata[6:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_SCALED_MODE:  prdata = 32'(scaled_ff);
         REG_EVERY_TRIPLE: prdata = 32'(triple_ff);
         REG_ROW_COUNT:    prdata = 32'(row_count_ff);
         REG_COLUMN_COUNT: prdata = 32'(column_count_ff);
      endcase
   end

   // sizes clamped to the store
   always_comb begin
      n_eff = (9'(row_count_ff) > SIZE_LIM) ? CW'(MAX_SIZE) : CW'(row_count_ff);
      m_eff = (9'(column_count_ff) > SIZE_LIM) ? CW'(MAX_SIZE) : CW'(column_count_ff);
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign acc                 = req_chan.valid && req_chan.ready;
   assign in_row              = AW'(req_chan.row_index);
   assign in_col              = AW'(req_chan.column_index);
   assign row_ok              = 9'(req_chan.row_index) < SIZE_LIM;
   assign col_ok              = 9'(req_chan.column_index) < SIZE_LIM;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.flag_count = rsp_data_ff;

   // memories
   assign col_a = (state_ff == ST_KLOOP) ? k_ff[AW-1:0] : j_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[{in_row, in_col}] <= req_chan.element_value;
      end
      mat_rd_a_ff <= mat_mem[{i_ff[AW-1:0], col_a}];
      mat_rd_b_ff <= mat_mem[{j_ff[AW-1:0], k_ff[AW-1:0]}];
   end

   always_ff @(posedge clock) begin
      if (scale_we) begin
         scale_mem[row_ff] <= r_ff;
      end
      scale_rd_a_ff <= scale_mem[i_ff[AW-1:0]];
      scale_rd_b_ff <= scale_mem[j_ff[AW-1:0]];
   end

   // root step and multipliers
   assign v_calc = 32'(req_chan.frequency) * (32'd65536 - 32'(req_chan.frequency));
   assign t_root = r_ff | (SCALE_W'(1) << bit_ff);
   assign t_sq   = 32'(t_root) * 32'(t_root);

   assign si_use = scaled_ff ? scale_rd_a_ff : SCALE_W'(1);
   assign sj_use = scaled_ff ? scale_rd_b_ff : SCALE_W'(1);
   assign mul_as = (state_ff == ST_PAIR_MUL) ? si_use : sj_ff;
   assign mul_bs = (state_ff == ST_PAIR_MUL) ? sj_use : si_ff;
   assign mul_bx = (state_ff == ST_PAIR_MUL) ? mat_rd_a_ff : mat_rd_b_ff;
   assign mul_a  = mat_rd_a_ff * $signed({1'b0, mul_as});
   assign mul_b  = mul_bx * $signed({1'b0, mul_bs});

   assign unit_i  = $signed(SW'({1'b0, si_ff})) <<< ONE_SHIFT;
   assign unit_j  = $signed(SW'({1'b0, sj_ff})) <<< ONE_SHIFT;
   assign lhs_sum = SW'(pa_ff) + SW'(pb_ff);
   assign flag    = v3_ff && (lhs_ff > r12_ff) && (lhs_ff > r21_ff);

   always_ff @(posedge clock) begin
      if (acc) begin
         v_ff <= v_calc;
      end
      pa_ff  <= mul_a;
      pb_ff  <= mul_b;
      lhs_ff <= mag_of(lhs_sum);
   end

   // control
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      bit_in       = bit_ff;
      r_in         = r_ff;
      row_in       = row_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      r12_in       = r12_ff;
      r21_in       = r21_ff;
      hit_in       = hit_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      issue_v      = 1'b0;
      mat_we       = 1'b0;
      scale_we     = 1'b0;
      j_next       = CW1'(j_ff) + CW1'(1);
      i_next2      = CW1'(i_ff) + CW1'(2);

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (flag) begin
         hit_in = 1'b1;
         if (triple_ff && count_ff != COUNT_MAX) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               priority case (req_chan.func)
                  FUNC_LOAD_ELEMENT: begin
                     mat_we = row_ok && col_ok;
                  end
                  FUNC_LOAD_FREQ: begin
                     if (row_ok) begin
                        row_in   = in_row;
                        r_in     = '0;
                        bit_in   = 4'd15;
                        state_in = ST_ROOT;
                     end
                  end
                  FUNC_START: begin
                     count_in = '0;
                     i_in     = '0;
                     j_in     = CW'(1);
                     state_in = (n_eff >= CW'(2)) ? ST_PAIR_RD : ST_DONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ROOT: begin
            if (t_sq <= v_ff) begin
               r_in = t_root;
            end
            bit_in = bit_ff - 4'd1;
            if (bit_ff == 4'd0) begin
               state_in = ST_SCALE_WR;
            end
         end
         ST_SCALE_WR: begin
            scale_we = 1'b1;
            state_in = ST_IDLE;
         end
         ST_PAIR_RD: begin
            state_in = ST_PAIR_MUL;
         end
         ST_PAIR_MUL: begin
            si_in    = si_use;
            sj_in    = sj_use;
            state_in = ST_PAIR_CMP;
         end
         ST_PAIR_CMP: begin
            r12_in   = mag_of(unit_j + SW'(pa_ff));
            r21_in   = mag_of(unit_i + SW'(pb_ff));
            k_in     = '0;
            hit_in   = 1'b0;
            state_in = ST_KLOOP;
         end
         ST_KLOOP: begin
            if (k_ff < m_eff) begin
               issue_v = (k_ff != i_ff) && (k_ff != j_ff);
               k_in    = k_ff + CW'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               if (!triple_ff && hit_ff && count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               if (j_next < CW1'(n_eff)) begin
                  j_in     = j_ff + CW'(1);
                  state_in = ST_PAIR_RD;
               end else if (i_next2 < CW1'(n_eff)) begin
                  i_in     = i_ff + CW'(1);
                  j_in     = i_ff + CW'(2);
                  state_in = ST_PAIR_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         bit_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         v1_ff        <= issue_v;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         bit_ff       <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      row_ff      <= row_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      r12_ff      <= r12_in;
      r21_ff      <= r21_in;
      rsp_data_ff <= rsp_data_in;
   end

   `CPC_ASSERT_IMP(a_load_when_idle, clock, reset, mat_we, state_ff == ST_IDLE, "matrix write outside idle")
   `CPC_ASSERT_IMP(a_pipe_in_scan, clock, reset, v3_ff, state_ff == ST_KLOOP || state_ff == ST_DRAIN, "column pipeline busy outside a pair")
   `CPC_ASSERT_NXT(a_root_length, clock, reset, state_ff == ST_ROOT && bit_ff == 4'd0, state_ff == ST_SCALE_WR, "root did not end after last bit")
   `CPC_ASSERT_NXT(a_done_result, clock, reset, state_ff == ST_DONE && (!rsp_valid_ff || rsp_chan.ready), rsp_valid_ff && rsp_data_ff == $past(count_ff), "count result not presented")

endmodule

>>> verif/cpc_checker.sv
`timescale 1ns / 1ps

module cpc_checker
   import cpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   cpc_req_if          req,
   cpc_rsp_if          rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending_count
);

   logic signed [15:0]  matrix_mirror [64][64];
   logic [SCALE_W-1:0]  scale_mirror [64];
   logic                scaled_on;
   logic                every_triple_on;
   logic [6:0]          rows_in_use;
   logic [6:0]          cols_in_use;
   logic [COUNT_W-1:0]  expected_counts [$];

   function automatic logic [SCALE_W-1:0] scale_of(logic [FREQ_W-1:0] p);
      logic [31:0]  v;
      logic [15:0]  r;
      logic [15:0]  t;
      v = 32'(p) * (32'd65536 - 32'(p));
      r = '0;
      for (int b = 15; b >= 0; b--) begin
         t = r | (16'd1 << b);
         if (64'(t) * 64'(t) <= 64'(v)) r = t;
      end
      return r;
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic [COUNT_W-1:0] count_flags();
      int      n;
      int      m;
      longint  one;
      longint  si;
      longint  sj;
      longint  xij;
      longint  r12;
      longint  r21;
      longint  lhs;
      logic [COUNT_W-1:0] tally;
      one = 64'sd16384;
      n = (rows_in_use > 64) ? 64 : int'(rows_in_use);
      m = (cols_in_use > 64) ? 64 : int'(cols_in_use);
      tally = '0;
      for (int i = 0; i + 1 < n; i++) begin
         for (int j = i + 1; j < n; j++) begin
            si = scaled_on ? longint'(scale_mirror[i]) : 1;
            sj = scaled_on ? longint'(scale_mirror[j]) : 1;
            xij = longint'(matrix_mirror[i][j]);
            r12 = magnitude(sj * one + xij * si);
            r21 = magnitude(si * one + xij * sj);
            for (int k = 0; k < m; k++) begin
               if (k == i || k == j) continue;
               lhs = magnitude(longint'(matrix_mirror[i][k]) * sj
                               + longint'(matrix_mirror[j][k]) * si);
               if (lhs > r12 && lhs > r21) begin
                  if (tally != COUNT_MAX) tally++;
                  if (!every_triple_on) break;
               end
            end
         end
      end
      return tally;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [COUNT_W-1:0] want;
      if (reset) begin
         scaled_on <= 1'b0;
         every_triple_on <= 1'b0;
         rows_in_use <= '0;
         cols_in_use <= '0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_SCALED_MODE:  scaled_on <= pwdata[0];
               REG_EVERY_TRIPLE: every_triple_on <= pwdata[0];
               REG_ROW_COUNT:    rows_in_use <= pwdata[6:0];
               REG_COLUMN_COUNT: cols_in_use <= pwdata[6:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_counts.size() == 0) begin
               report_mismatch($sformatf("unexpected count beat %0d", rsp.flag_count));
            end else begin
               want = expected_counts.pop_front();
               if (rsp.flag_count !== want)
                  report_mismatch($sformatf("flag_count %0d, wanted %0d",
                                            rsp.flag_count, want));
            end
         end
         if (req.valid && req.ready) begin
            case (req.func)
               FUNC_LOAD_ELEMENT: matrix_mirror[req.row_index][req.column_index] =
                  req.element_value;
               FUNC_LOAD_FREQ: scale_mirror[req.row_index] = scale_of(req.frequency);
               FUNC_START: expected_counts.push_back(count_flags());
               default: ;
            endcase
         end
         pending_count = expected_counts.size();
      end
   end

endmodule

>>> verif/tb_correlation_pattern_counter.sv
`timescale 1ns / 1ps

module tb_correlation_pattern_counter;
   import cpc_pkg::*;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          pending_count;
   bit          no_idle;
   bit          element_written [64][64];
   bit          scale_written [64];
   int          n_rows;
   int          n_cols;
   bit          scaled;

   cpc_req_if #(.VALUE_WIDTH(16)) req_chan ();
   cpc_rsp_if rsp_chan ();

   correlation_pattern_counter i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   cpc_checker i_checker (
      .clock(clock), .reset(reset), .req(req_chan), .rsp(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL correlation_pattern_counter");
      $finish;
   end

   function automatic int idle_draw();
      return no_idle ? 0 : int'($urandom_range(0, 5));
   endfunction

   function automatic logic [15:0] pick_element();
      case ($urandom_range(0, 6))
         0: return -16'sd16384;
         1: return 16'sd16384;
         2: return 16'(-16384 + int'($urandom_range(0, 1000)));
         3: return 16'($urandom);
         4: return 16'(int'($urandom_range(0, 400)) - 200);
         default: return 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic logic [15:0] pick_frequency();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hffff;
         2: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_request(logic [1:0] f, logic [5:0] r, logic [5:0] c,
                               logic [15:0] v, logic [15:0] p);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= f;
      req_chan.row_index <= r;
      req_chan.column_index <= c;
      req_chan.element_value <= v;
      req_chan.frequency <= p;
      do @(posedge clock); while (!req_chan.ready);
      if (f == FUNC_LOAD_ELEMENT) element_written[r][c] = 1'b1;
      if (f == FUNC_LOAD_FREQ) scale_written[r] = 1'b1;
   endtask

   task automatic load_element(int r, int c, logic [15:0] v);
      push_request(FUNC_LOAD_ELEMENT, 6'(r), 6'(c), v, 16'($urandom));
   endtask

   task automatic load_frequency(int r, logic [15:0] p);
      push_request(FUNC_LOAD_FREQ, 6'(r), 6'($urandom), 16'($urandom), p);
   endtask

   // every entry a count reads must hold a written value
   task automatic start_count();
      int span;
      span = (n_rows > n_cols) ? n_rows : n_cols;
      for (int i = 0; i < n_rows; i++) begin
         for (int c = 0; c < span; c++)
            if (!element_written[i][c]) load_element(i, c, pick_element());
         if (scaled && !scale_written[i]) load_frequency(i, pick_frequency());
      end
      push_request(FUNC_START, 6'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic csr_write(logic [1:0] idx, int unsigned value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic configure(bit s, bit e, int r, int c);
      settle();
      csr_write(REG_SCALED_MODE, s);
      csr_write(REG_EVERY_TRIPLE, e);
      csr_write(REG_ROW_COUNT, r);
      csr_write(REG_COLUMN_COUNT, c);
      scaled = s;
      n_rows = (r > 64) ? 64 : r;
      n_cols = (c > 64) ? 64 : c;
   endtask

   // response side stalls
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = idle_draw();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   initial begin
      int phase_cfg [14][4] = '{
         '{0, 0, 4, 4}, '{1, 1, 5, 6}, '{0, 1, 8, 3}, '{1, 0, 3, 8},
         '{1, 1, 2, 2}, '{0, 0, 12, 0}, '{1, 1, 10, 10}, '{0, 1, 2, 127},
         '{1, 0, 12, 5}, '{0, 1, 6, 6}, '{1, 1, 7, 4}, '{0, 0, 3, 3},
         '{1, 1, 4, 7}, '{0, 1, 12, 1}
      };
      int made;
      int span;
      int burst;
      bit big;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.func = '0;
      req_chan.row_index = '0;
      req_chan.column_index = '0;
      req_chan.element_value = '0;
      req_chan.frequency = '0;
      no_idle = 1'b0;
      scaled = 1'b0;
      n_rows = 0;
      n_cols = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset-state count, extremes, ignored func, special frequencies
      start_count();
      push_request(FUNC_UNUSED, 6'h3f, 6'h3f, 16'hffff, 16'hffff);
      configure(1, 1, 3, 4);
      load_element(0, 1, -16'sd16384);
      load_element(0, 2, 16'sd16384);
      load_element(1, 2, 16'sd16384);
      load_element(63, 63, 16'sd16384);
      load_element(2, 0, -16'sd16384);
      load_frequency(0, 16'd0);
      load_frequency(1, 16'hffff);
      load_frequency(2, 16'h8000);
      load_frequency(63, 16'd1);
      start_count();
      configure(0, 0, 3, 4);
      start_count();
      configure(0, 1, 3, 4);
      start_count();

      for (int ph = 0; ph < 14; ph++) begin
         configure(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2], phase_cfg[ph][3]);
         no_idle = (ph % 4 == 3);
         big = (n_rows * n_cols > 200) || n_rows > 20;
         span = (n_rows > n_cols) ? n_rows : n_cols;
         if (span == 0) span = 1;
         made = 0;
         while (made < (big ? 8 : 40)) begin
            if ($urandom_range(0, 9) < 7) begin
               burst = $urandom_range(1, 8);
               repeat (burst) begin
                  if ($urandom_range(0, 3) == 0 && n_rows > 0)
                     load_frequency($urandom_range(0, n_rows - 1), pick_frequency());
                  else
                     load_element($urandom_range(0, (n_rows > 0 ? n_rows : 1) - 1),
                                  $urandom_range(0, span - 1), pick_element());
               end
               made += burst;
               if (!big || made >= 8) begin
                  start_count();
                  made++;
               end
            end else begin
               case ($urandom_range(0, 3))
                  0: load_element($urandom_range(0, 63), $urandom_range(0, 63),
                                  pick_element());
                  1: load_frequency($urandom_range(0, 63), pick_frequency());
                  2: if (!big) start_count();
                  default: push_request(FUNC_UNUSED, 6'($urandom), 6'($urandom),
                                        16'($urandom), 16'($urandom));
               endcase
               made++;
            end
         end
      end

      settle();
      if (fail_count == 0)
         $display("PASS correlation_pattern_counter");
      else
         $display("FAIL correlation_pattern_counter");
      $finish;
   end

endmodule
